@@ rtl/depth_pixel_backprojection_defines.svh @@
// Assertion macros for the depth pixel back-projection block.
// Included by the RTL modules that check their own pipeline timing.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DPB_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dpb assertion failed");
`define DPB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dpb assertion failed");
`else
`define DPB_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define DPB_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

@@ rtl/dpb_pkg.sv @@
// Shared types and constants for the depth pixel back-projection block.
// No dependencies.
package dpb_pkg;

  localparam int NUM_W = 32;
  localparam int DEN_W = 16;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS_PER_STAGE;

  localparam logic [23:0] COORD_MAX = 24'h7fffff;
  localparam logic [23:0] COORD_MIN = 24'h800000;
  localparam logic [31:0] POS_LIMIT = 32'd8388607;
  localparam logic [31:0] NEG_LIMIT = 32'd8388608;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_MIN_DEPTH = 3'd4,
    REG_MAX_DEPTH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        zero_x;
    logic        zero_y;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } side_t;

endpackage

@@ rtl/dpb_div.sv @@
// Pipelined unsigned divider, 32-bit numerator by 16-bit divisor.
// Depends on dpb_pkg and the assertion macro header.
`include "depth_pixel_backprojection_defines.svh"
module dpb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [dpb_pkg::NUM_W-1:0]  num,
  input  logic [dpb_pkg::DEN_W-1:0]  den,
  output logic                       out_valid,
  output logic [dpb_pkg::NUM_W-1:0]  quo
);

  localparam int STAGES = dpb_pkg::DIV_STAGES;

  typedef struct packed {
    logic [dpb_pkg::DEN_W-1:0] r;
    logic [dpb_pkg::NUM_W-1:0] n;
  } step_t;

  function automatic step_t div_steps(input logic [dpb_pkg::DEN_W-1:0] r_in,
                                      input logic [dpb_pkg::NUM_W-1:0] n_in,
                                      input logic [dpb_pkg::DEN_W-1:0] d);
    logic [dpb_pkg::DEN_W:0]   acc;
    logic [dpb_pkg::DEN_W-1:0] rr;
    logic [dpb_pkg::NUM_W-1:0] nn;
    step_t                     res;
    rr = r_in;
    nn = n_in;
    for (int k = 0; k < dpb_pkg::DIV_BITS_PER_STAGE; k++) begin
      acc = {rr, nn[dpb_pkg::NUM_W-1]};
      nn  = {nn[dpb_pkg::NUM_W-2:0], 1'b0};
      if (acc >= {1'b0, d}) begin
        acc   = acc - {1'b0, d};
        nn[0] = 1'b1;
      end
      rr = acc[dpb_pkg::DEN_W-1:0];
    end
    res.r = rr;
    res.n = nn;
    return res;
  endfunction

  logic                      vld [STAGES];
  logic [dpb_pkg::DEN_W-1:0] rem [STAGES];
  logic [dpb_pkg::NUM_W-1:0] nq  [STAGES];
  logic [dpb_pkg::DEN_W-1:0] dv  [STAGES];
  step_t                     stage_next [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        stage_next[s] = div_steps('0, num, den);
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else begin
          vld[s] <= in_valid;
        end
        rem[s] <= stage_next[s].r;
        nq[s]  <= stage_next[s].n;
        dv[s]  <= den;
      end
    end else begin : g_rest
      always_comb begin
        stage_next[s] = div_steps(rem[s-1], nq[s-1], dv[s-1]);
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else begin
          vld[s] <= vld[s-1];
        end
        rem[s] <= stage_next[s].r;
        nq[s]  <= stage_next[s].n;
        dv[s]  <= dv[s-1];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quo       = nq[STAGES-1];

  `DPB_ASSERT_IMPLY(a_rem_below_den, clk, rst, vld[STAGES-1] && dv[STAGES-1] != '0, rem[STAGES-1] < dv[STAGES-1])

endmodule

@@ rtl/depth_pixel_backprojection.sv @@
// Top level: pinhole back-projection of RGB-D pixels into colored points.
// Depends on dpb_pkg, dpb_div and the assertion macro header.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  pixel    | start / busy       | pixel_row, pixel_col, depth_mm, rgb in
//  point    | done (strobe)      | point_x/y/z_mm, blue/green/red_out
//  config   | APB psel/penable   | paddr, pwdata, prdata (six 16-bit regs)
//
// One request per cycle while busy is low; a kept pixel gives its point through:
// an input stage, a multiply stage, 8 divider stages of 4 quotient bits each, and
// the output register. busy is high only during reset. Dropped pixels give no strobe.
// Reset clears the valid bits and loads the register defaults.
`include "depth_pixel_backprojection_defines.svh"
module depth_pixel_backprojection #(
  parameter int SUBSAMPLE_STRIDE = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        pixel_row,
  input  logic [11:0]        pixel_col,
  input  logic [15:0]        depth_mm,
  input  logic [7:0]         blue_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         red_in,
  output logic               done,
  output logic signed [23:0] point_x_mm,
  output logic signed [23:0] point_y_mm,
  output logic [15:0]        point_z_mm,
  output logic [7:0]         blue_out,
  output logic [7:0]         green_out,
  output logic [7:0]         red_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [24:0] STRIDE_RECIP =
    25'((2**24 + SUBSAMPLE_STRIDE - 1) / SUBSAMPLE_STRIDE);
  localparam int LATENCY = dpb_pkg::DIV_STAGES + 3;

  logic [15:0] focal_x_q4, focal_y_q4, center_x_q4, center_y_q4;
  logic [15:0] min_depth_mm, max_depth_mm;
  logic [2:0]  reg_sel;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign busy      = rst;
  assign reg_sel   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x_q4   <= 16'd8400;
      focal_y_q4   <= 16'd8400;
      center_x_q4  <= 16'd5120;
      center_y_q4  <= 16'd3840;
      min_depth_mm <= 16'd10;
      max_depth_mm <= 16'd5000;
    end else if (cfg_write) begin
      unique case (reg_sel)
        dpb_pkg::REG_FOCAL_X:   focal_x_q4   <= pwdata[15:0];
        dpb_pkg::REG_FOCAL_Y:   focal_y_q4   <= pwdata[15:0];
        dpb_pkg::REG_CENTER_X:  center_x_q4  <= pwdata[15:0];
        dpb_pkg::REG_CENTER_Y:  center_y_q4  <= pwdata[15:0];
        dpb_pkg::REG_MIN_DEPTH: min_depth_mm <= pwdata[15:0];
        dpb_pkg::REG_MAX_DEPTH: max_depth_mm <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dpb_pkg::REG_FOCAL_X:   prdata = {16'd0, focal_x_q4};
      dpb_pkg::REG_FOCAL_Y:   prdata = {16'd0, focal_y_q4};
      dpb_pkg::REG_CENTER_X:  prdata = {16'd0, center_x_q4};
      dpb_pkg::REG_CENTER_Y:  prdata = {16'd0, center_y_q4};
      dpb_pkg::REG_MIN_DEPTH: prdata = {16'd0, min_depth_mm};
      dpb_pkg::REG_MAX_DEPTH: prdata = {16'd0, max_depth_mm};
      default:                prdata = '0;
    endcase
  end

  // input stage
  logic [15:0] p16_x, p16_y;
  logic [36:0] prod_col, prod_row;
  logic        v1, win1, neg_x1, neg_y1;
  logic [15:0] mag_x1, mag_y1;
  logic [23:0] low_col1, low_row1;
  logic [15:0] depth1;
  logic [7:0]  blue1, green1, red1;

  assign p16_x    = {pixel_col, 4'b0};
  assign p16_y    = {pixel_row, 4'b0};
  assign prod_col = 37'(pixel_col) * 37'(STRIDE_RECIP);
  assign prod_row = 37'(pixel_row) * 37'(STRIDE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    win1     <= (depth_mm >= min_depth_mm) && (depth_mm <= max_depth_mm);
    neg_x1   <= center_x_q4 > p16_x;
    neg_y1   <= center_y_q4 > p16_y;
    mag_x1   <= (center_x_q4 > p16_x) ? center_x_q4 - p16_x : p16_x - center_x_q4;
    mag_y1   <= (center_y_q4 > p16_y) ? center_y_q4 - p16_y : p16_y - center_y_q4;
    low_col1 <= prod_col[23:0];
    low_row1 <= prod_row[23:0];
    depth1   <= depth_mm;
    blue1    <= blue_in;
    green1   <= green_in;
    red1     <= red_in;
  end

  // multiply stage
  logic                       v2;
  logic [dpb_pkg::NUM_W-1:0]  num_x2, num_y2;
  dpb_pkg::side_t             side2;
  logic                       keep1;

  assign keep1 = win1 && ({1'b0, low_col1} < STRIDE_RECIP)
                      && ({1'b0, low_row1} < STRIDE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && keep1;
    end
    num_x2       <= 32'(mag_x1) * 32'(depth1);
    num_y2       <= 32'(mag_y1) * 32'(depth1);
    side2.neg_x  <= neg_x1;
    side2.neg_y  <= neg_y1;
    side2.zero_x <= (mag_x1 == '0) || (depth1 == '0);
    side2.zero_y <= (mag_y1 == '0) || (depth1 == '0);
    side2.depth  <= depth1;
    side2.blue   <= blue1;
    side2.green  <= green1;
    side2.red    <= red1;
  end

  // divide stages
  logic                      dv_x, dv_y;
  logic [dpb_pkg::NUM_W-1:0] quo_x, quo_y;
  dpb_pkg::side_t            side_dly [dpb_pkg::DIV_STAGES];

  dpb_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (num_x2),
    .den       (focal_x_q4),
    .out_valid (dv_x),
    .quo       (quo_x)
  );

  dpb_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (num_y2),
    .den       (focal_y_q4),
    .out_valid (dv_y),
    .quo       (quo_y)
  );

  always_ff @(posedge clk) begin
    side_dly[0] <= side2;
    for (int i = 1; i < dpb_pkg::DIV_STAGES; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  function automatic logic [23:0] saturate(input logic [31:0] q, input logic neg,
                                           input logic zero);
    logic [31:0] nq;
    nq = -q;
    if (zero) begin
      return '0;
    end else if (neg) begin
      return (q > dpb_pkg::NEG_LIMIT) ? dpb_pkg::COORD_MIN : nq[23:0];
    end else begin
      return (q > dpb_pkg::POS_LIMIT) ? dpb_pkg::COORD_MAX : q[23:0];
    end
  endfunction

  // output stage
  dpb_pkg::side_t side_last;
  assign side_last = side_dly[dpb_pkg::DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_x && dv_y;
    end
    point_x_mm <= saturate(quo_x, side_last.neg_x, side_last.zero_x);
    point_y_mm <= saturate(quo_y, side_last.neg_y, side_last.zero_y);
    point_z_mm <= side_last.depth;
    blue_out   <= side_last.blue;
    green_out  <= side_last.green;
    red_out    <= side_last.red;
  end

  `DPB_ASSERT_NEXT(a_accept_enters, clk, rst, start && !busy, v1)
  `DPB_ASSERT_IMPLY(a_done_from_request, clk, rst, done, $past(start, LATENCY))
  `DPB_ASSERT_IMPLY(a_depth_aligned, clk, rst, done, point_z_mm == $past(depth_mm, LATENCY))
  `DPB_ASSERT_IMPLY(a_div_aligned, clk, rst, done, $past(v2, dpb_pkg::DIV_STAGES + 1))

endmodule
